>>> rtl/core/markov_miss_prefetch_table_top_defines.svh
// Assertion macros for the Markov miss prefetch table checker.
// Included by mmpt_chk.sv; depends on i_clk and i_rst_n in the including scope.
`ifndef MARKOV_MISS_PREFETCH_TABLE_TOP_DEFINES_SVH
`define MARKOV_MISS_PREFETCH_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define MMPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mmpt assertion failed");

// next-cycle implication
`define MMPT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mmpt assertion failed");

`endif

>>> rtl/core/mmpt_pkg.sv
// Shared constants and helpers for the Markov miss prefetch table.
// No dependencies.
package mmpt_pkg;

    localparam int ADDR_W      = 32;
    localparam int OFF_W       = 4;
    localparam logic [OFF_W-1:0] OFF_MAX   = 4'd12;
    localparam logic [OFF_W-1:0] OFF_RESET = 4'd6;

    function automatic logic [ADDR_W-1:0] line_align(input logic [ADDR_W-1:0] addr,
                                                     input logic [OFF_W-1:0]  off);
        logic [OFF_W-1:0]  sat;
        logic [ADDR_W-1:0] mask;
        sat  = (off > OFF_MAX) ? OFF_MAX : off;
        mask = {ADDR_W{1'b1}} << sat;
        return addr & mask;
    endfunction

endpackage

>>> rtl/core/markov_miss_prefetch_table_top.sv
// Markov miss prefetch table: top level with scan sequencer and row storage.
// Depends on mmpt_pkg and mmpt_ram.
//
// Usage:
//   Input channel i_valid/o_stall carries one miss address per transaction.
//   Output channel o_valid/i_stall returns exactly one result per input:
//   hit/full flags and up to two successor line addresses to prefetch.
//   Config channel i_cfg_valid/o_cfg_ready writes line_offset_bits; write it
//   only while no transaction is in flight.
// Timing:
//   Keys live in a RAM and one shared comparator checks one row per cycle.
//   After a hit in row r the scan stops there; a miss scans all ROWS rows. The
//   states S_HRD, S_HCAP, S_PWR and S_DONE follow, and o_valid rises once
//   the result is registered. o_stall stays high meanwhile, so one miss is in
//   flight at a time. The next item is accepted while a finished result waits
//   in the output register. A stalled result holds until i_stall drops.
// Reset:
//   Synchronous, active low; clears all valid bits, the previous-row link and
//   sets line_offset_bits to 6. No clearing pass is needed.
module markov_miss_prefetch_table_top #(
    parameter int ROWS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [mmpt_pkg::ADDR_W-1:0] i_miss_addr,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mmpt_pkg::OFF_W-1:0]  i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_table_hit,
    output logic                        o_table_full,
    output logic                        o_first_valid,
    output logic [mmpt_pkg::ADDR_W-1:0] o_first_addr,
    output logic                        o_second_valid,
    output logic [mmpt_pkg::ADDR_W-1:0] o_second_addr
);

    localparam int AW = mmpt_pkg::ADDR_W;
    localparam int IW = $clog2(ROWS);
    localparam logic [IW-1:0] LAST = IW'(ROWS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HRD,
        S_HCAP,
        S_PWR,
        S_DONE
    } t_state;

    t_state r_state;

    logic [mmpt_pkg::OFF_W-1:0] r_line_off;
    logic [AW-1:0]   r_line;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   r_rd_idx;
    logic            r_rd_pend;
    logic            r_free_found;
    logic [IW-1:0]   r_free_idx;
    logic            r_hit;
    logic            r_full;
    logic            r_have;
    logic [IW-1:0]   r_row;
    logic [ROWS-1:0] r_key_vld;
    logic [ROWS-1:0] r_s1_vld;
    logic [ROWS-1:0] r_s2_vld;
    logic            r_prev_vld;
    logic [IW-1:0]   r_prev_idx;
    logic            r_f_vld;
    logic [AW-1:0]   r_f_addr;
    logic            r_s_vld;
    logic [AW-1:0]   r_s_addr;

    logic            r_o_valid;
    logic            r_o_hit;
    logic            r_o_full;
    logic            r_o_f_vld;
    logic [AW-1:0]   r_o_f_addr;
    logic            r_o_s_vld;
    logic [AW-1:0]   r_o_s_addr;

    logic [AW-1:0]   key_rdata;
    logic            key_we;
    logic [2*AW-1:0] succ_rdata;
    logic [2*AW-1:0] succ_wdata;
    logic            succ_we;
    logic [IW-1:0]   succ_raddr;
    logic            key_match;
    logic            free_any;
    logic [IW-1:0]   free_now;
    logic            scan_end;
    logic            out_load;

    mmpt_ram #(.WIDTH(AW), .DEPTH(ROWS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (free_now),
        .i_wdata (r_line),
        .i_raddr (r_idx),
        .o_rdata (key_rdata)
    );

    // successor word: {succ_two, succ_one}
    mmpt_ram #(.WIDTH(2 * AW), .DEPTH(ROWS)) u_succ_ram (
        .i_clk   (i_clk),
        .i_we    (succ_we),
        .i_waddr (r_prev_idx),
        .i_wdata (succ_wdata),
        .i_raddr (succ_raddr),
        .o_rdata (succ_rdata)
    );

    always_comb begin
        key_match  = r_rd_pend && r_key_vld[r_rd_idx] && (key_rdata == r_line);
        free_any   = r_free_found || !r_key_vld[r_rd_idx];
        free_now   = r_free_found ? r_free_idx : r_rd_idx;
        scan_end   = (r_state == S_SCAN) && r_rd_pend && !key_match && (r_rd_idx == LAST);
        key_we     = scan_end && free_any;
        succ_raddr = (r_state == S_HRD) ? r_row : r_prev_idx;
        succ_we    = (r_state == S_PWR) && r_prev_vld;
        if (!r_s1_vld[r_prev_idx]) begin
            succ_wdata = {succ_rdata[2*AW-1:AW], r_line};
        end else if (!r_s2_vld[r_prev_idx]) begin
            succ_wdata = {r_line, succ_rdata[AW-1:0]};
        end else begin
            succ_wdata = {r_line, succ_rdata[2*AW-1:AW]};
        end
        out_load = (r_state == S_DONE) && (!r_o_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_line_off   <= mmpt_pkg::OFF_RESET;
            r_idx        <= '0;
            r_rd_pend    <= 1'b0;
            r_free_found <= 1'b0;
            r_hit        <= 1'b0;
            r_full       <= 1'b0;
            r_have       <= 1'b0;
            r_key_vld    <= '0;
            r_s1_vld     <= '0;
            r_s2_vld     <= '0;
            r_prev_vld   <= 1'b0;
            r_prev_idx   <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_line_off <= i_cfg_data;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_line       <= mmpt_pkg::line_align(i_miss_addr, r_line_off);
                        r_idx        <= '0;
                        r_rd_pend    <= 1'b0;
                        r_free_found <= 1'b0;
                        r_hit        <= 1'b0;
                        r_full       <= 1'b0;
                        r_have       <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_idx  <= r_idx;
                    r_rd_pend <= 1'b1;
                    if (r_idx != LAST) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (key_match) begin
                        r_hit   <= 1'b1;
                        r_have  <= 1'b1;
                        r_row   <= r_rd_idx;
                        r_state <= S_HRD;
                    end else if (r_rd_pend) begin
                        if (!r_free_found && !r_key_vld[r_rd_idx]) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_rd_idx;
                        end
                        if (scan_end) begin
                            if (free_any) begin
                                r_key_vld[free_now] <= 1'b1;
                                r_row               <= free_now;
                                r_have              <= 1'b1;
                            end else begin
                                r_full <= 1'b1;
                            end
                            r_state <= S_HRD;
                        end
                    end
                end
                S_HRD: begin
                    r_state <= S_HCAP;
                end
                S_HCAP: begin
                    r_f_vld  <= r_hit && r_s1_vld[r_row];
                    r_f_addr <= (r_hit && r_s1_vld[r_row]) ? succ_rdata[AW-1:0] : '0;
                    r_s_vld  <= r_hit && r_s2_vld[r_row];
                    r_s_addr <= (r_hit && r_s2_vld[r_row]) ? succ_rdata[2*AW-1:AW] : '0;
                    r_state  <= S_PWR;
                end
                S_PWR: begin
                    if (r_prev_vld) begin
                        if (!r_s1_vld[r_prev_idx]) begin
                            r_s1_vld[r_prev_idx] <= 1'b1;
                        end else if (!r_s2_vld[r_prev_idx]) begin
                            r_s2_vld[r_prev_idx] <= 1'b1;
                        end
                    end
                    r_prev_vld <= r_have;
                    r_prev_idx <= r_have ? r_row : '0;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_o_hit    <= r_hit;
                        r_o_full   <= r_full;
                        r_o_f_vld  <= r_f_vld;
                        r_o_f_addr <= r_f_addr;
                        r_o_s_vld  <= r_s_vld;
                        r_o_s_addr <= r_s_addr;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall        = !i_rst_n || (r_state != S_IDLE);
    assign o_cfg_ready    = i_rst_n;
    assign o_valid        = r_o_valid;
    assign o_table_hit    = r_o_hit;
    assign o_table_full   = r_o_full;
    assign o_first_valid  = r_o_f_vld;
    assign o_first_addr   = r_o_f_addr;
    assign o_second_valid = r_o_s_vld;
    assign o_second_addr  = r_o_s_addr;

endmodule

>>> rtl/core/mmpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mmpt_chk.sv
// Port-level checker for the Markov miss prefetch table, bound to the top level.
// Depends on mmpt_pkg and markov_miss_prefetch_table_top_defines.svh.
`include "markov_miss_prefetch_table_top_defines.svh"

module mmpt_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic                        o_table_hit,
    input logic                        o_table_full,
    input logic                        o_first_valid,
    input logic [mmpt_pkg::ADDR_W-1:0] o_first_addr,
    input logic                        o_second_valid,
    input logic [mmpt_pkg::ADDR_W-1:0] o_second_addr
);

    `MMPT_ASSERT_NXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `MMPT_ASSERT_IMP(a_hit_full_excl, o_valid, !(o_table_hit && o_table_full))
    `MMPT_ASSERT_IMP(a_cand_only_on_hit, o_valid && !o_table_hit,
        !o_first_valid && !o_second_valid && (o_first_addr == '0) && (o_second_addr == '0))
    `MMPT_ASSERT_NXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_first_addr) && $stable(o_second_addr))

endmodule

bind markov_miss_prefetch_table_top mmpt_chk u_mmpt_chk (.*);

>>> tb/tb_markov_miss_prefetch_table_top.sv
// Testbench for markov_miss_prefetch_table_top: random and directed miss traffic,
// a self-predicting scoreboard class, and stall/idle pressure on both channels.
// Depends on mmpt_pkg and the block's RTL only.
module tb_markov_miss_prefetch_table_top;

    localparam int AW              = mmpt_pkg::ADDR_W;
    localparam int OW              = mmpt_pkg::OFF_W;
    localparam int ROWS            = 16;
    localparam int LIMIT_CYCLES    = 1_500_000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = ROWS + 10;
    localparam int ITEMS_PER_PHASE = 225;

    typedef struct {
        logic          hit;
        logic          full;
        logic          first_valid;
        logic [AW-1:0] first_addr;
        logic          second_valid;
        logic [AW-1:0] second_addr;
    } t_candidates;

    class t_markov_table_sb;
        logic [AW-1:0]  key    [ROWS];
        bit             key_v  [ROWS];
        logic [AW-1:0]  succ_a [ROWS];
        bit             succ_a_v [ROWS];
        logic [AW-1:0]  succ_b [ROWS];
        bit             succ_b_v [ROWS];
        int unsigned    last_row;
        bit             last_row_v;
        logic [OW-1:0]  offset;
        t_candidates    pending[$];
        int             errors, checked, noted, hits, fulls;

        function new();
            offset = mmpt_pkg::OFF_RESET;
        endfunction

        function logic [AW-1:0] line_mask();
            return {AW{1'b1}} << ((offset > mmpt_pkg::OFF_MAX) ? mmpt_pkg::OFF_MAX : offset);
        endfunction

        function void note_miss(logic [AW-1:0] addr);
            t_candidates   c;
            logic [AW-1:0] line;
            int            row;
            line = addr & line_mask();
            c = '{default: '0};
            row = -1;
            noted++;
            foreach (key_v[i]) if (row < 0 && key_v[i] && key[i] == line) row = i;
            if (row >= 0) begin
                c.hit = 1'b1;
                hits++;
                c.first_valid  = succ_a_v[row];
                c.second_valid = succ_b_v[row];
                if (succ_a_v[row]) c.first_addr = succ_a[row];
                if (succ_b_v[row]) c.second_addr = succ_b[row];
            end else begin
                foreach (key_v[i]) if (row < 0 && !key_v[i]) row = i;
                if (row >= 0) begin
                    key[row]   = line;
                    key_v[row] = 1'b1;
                end else begin
                    c.full = 1'b1;
                    fulls++;
                end
            end
            // link this line as a successor of the previous row
            if (last_row_v) begin
                if (!succ_a_v[last_row]) begin
                    succ_a[last_row]   = line;
                    succ_a_v[last_row] = 1'b1;
                end else if (!succ_b_v[last_row]) begin
                    succ_b[last_row]   = line;
                    succ_b_v[last_row] = 1'b1;
                end else begin
                    succ_a[last_row] = succ_b[last_row];
                    succ_b[last_row] = line;
                end
            end
            last_row_v = (row >= 0);
            last_row   = (row >= 0) ? row : 0;
            pending.push_back(c);
        endfunction

        function void cmp_field(string name, logic [AW-1:0] want, logic [AW-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_candidates(t_candidates got);
            t_candidates want;
            if (pending.size() == 0) begin
                $error("result transaction with no miss outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            cmp_field("table_hit", AW'(want.hit), AW'(got.hit));
            cmp_field("table_full", AW'(want.full), AW'(got.full));
            cmp_field("first_valid", AW'(want.first_valid), AW'(got.first_valid));
            cmp_field("first_addr", want.first_addr, got.first_addr);
            cmp_field("second_valid", AW'(want.second_valid), AW'(got.second_valid));
            cmp_field("second_addr", want.second_addr, got.second_addr);
        endfunction

        // address that hits a stored row under the current alignment, if any
        function logic [AW-1:0] known_line_addr();
            logic [AW-1:0] m;
            int            aligned[$];
            m = line_mask();
            foreach (key_v[i]) if (key_v[i] && (key[i] & ~m) == '0) aligned.push_back(i);
            if (aligned.size() == 0) return $urandom;
            return key[aligned[$urandom_range(0, aligned.size() - 1)]] | ($urandom & ~m);
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic [AW-1:0] i_miss_addr;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [OW-1:0] i_cfg_data;
    logic          o_valid;
    logic          i_stall;
    logic          o_table_hit;
    logic          o_table_full;
    logic          o_first_valid;
    logic [AW-1:0] o_first_addr;
    logic          o_second_valid;
    logic [AW-1:0] o_second_addr;

    t_markov_table_sb sb;
    t_candidates      seen;
    bit               steady;
    bit               hold_req;
    int               cycle_count = 0;
    int               offset_writes = 0;

    markov_miss_prefetch_table_top #(.ROWS(ROWS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_miss_addr    (i_miss_addr),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_table_hit    (o_table_hit),
        .o_table_full   (o_table_full),
        .o_first_valid  (o_first_valid),
        .o_first_addr   (o_first_addr),
        .o_second_valid (o_second_valid),
        .o_second_addr  (o_second_addr)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("tb_markov_miss_prefetch_table_top: errors");
        $finish;
    end

    // mostly short gaps, a few long ones
    function int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady) return 0;
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver side: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        int stall_left;
        int open_left;
        hold_left  = 0;
        stall_left = 0;
        open_left  = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (open_left > 0) begin
                    open_left--;
                end else begin
                    stall_left = idle_len();
                    open_left  = $urandom_range(0, 20);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen.hit          = o_table_hit;
            seen.full         = o_table_full;
            seen.first_valid  = o_first_valid;
            seen.first_addr   = o_first_addr;
            seen.second_valid = o_second_valid;
            seen.second_addr  = o_second_addr;
            sb.check_candidates(seen);
        end
    end

    // called and returns at a falling edge
    task automatic send_miss(input logic [AW-1:0] addr);
        int gap;
        i_valid     <= 1'b1;
        i_miss_addr <= addr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_miss(addr);
        @(negedge i_clk);
        gap = idle_len();
        if (gap > 0) begin
            i_valid     <= 1'b0;
            i_miss_addr <= $urandom;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_offset(input logic [OW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.offset = value;
        offset_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n);
        logic [AW-1:0] addr;
        logic [AW-1:0] prev_addr;
        int            r;
        prev_addr = $urandom;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 75) addr = sb.known_line_addr();
            else if (r < 85) addr = prev_addr;
            else addr = $urandom;
            send_miss(addr);
            prev_addr = addr;
        end
    endtask

    initial begin
        logic [OW-1:0] phase_offs[8];
        logic [AW-1:0] k;
        phase_offs = '{4'd12, 4'd0, 4'd6, 4'd13, 4'd15, 4'd3, 4'd14, 4'd9};
        phase_offs[7] = OW'($urandom_range(0, 15));
        sb          = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_miss_addr = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset alignment: insert, repeat on the same row, successor shift
        send_miss(32'h0000_0000);
        send_miss(32'h0000_003F);
        send_miss(32'h0000_002A);
        send_miss(32'hFFFF_FFFF);
        send_miss(32'h0000_0000);
        for (int i = 2; i < ROWS; i++) begin
            k = ($urandom & 32'hFFFF_F000) | ((i >= 10) ? ($urandom & 32'h0000_0FC0) : 32'h0);
            send_miss(k | ($urandom & 32'h0000_003F));
        end
        send_miss(32'h8000_0040);
        send_miss(32'hFFFF_FFFF);

        // out-of-range offset saturates to 12
        wait_drained();
        write_offset(4'd15);
        send_miss(32'h0000_0FFF);
        send_miss(32'hFFFF_FFFF);

        wait_drained();
        write_offset(4'd0);
        send_miss(32'hFFFF_FFC0);
        send_miss(32'h0000_003F);

        foreach (phase_offs[p]) begin
            wait_drained();
            write_offset(phase_offs[p]);
            steady = (p == 2 || p == 5);
            if (p == 2) hold_req = 1'b1;
            run_phase(ITEMS_PER_PHASE);
        end
        wait_drained();
        steady = 1'b0;

        $display("Sent %0d misses across %0d offset settings: %0d table hits, %0d full-table misses.",
                 sb.noted, offset_writes, sb.hits, sb.fulls);
        $display("Checked %0d results, with a %0d-cycle receiver hold-off under full input load.",
                 sb.checked, HOLD_CYCLES);
        if (sb.errors == 0) begin
            $display("tb_markov_miss_prefetch_table_top: clean");
        end else begin
            $display("tb_markov_miss_prefetch_table_top: errors");
        end
        $finish;
    end
endmodule
